/* src/rect_point_count_assert.svh */
// ----------------------------------------------------------------------------
// rect_point_count assertion macros
// Shared property shapes for the rect_point_count checker.
// ----------------------------------------------------------------------------
`ifndef RECT_POINT_COUNT_ASSERT_SVH
`define RECT_POINT_COUNT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rect_point_count: check failed");

// next-cycle implication, sampled on clk, off during rst
`define RPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rect_point_count: check failed");

`endif

/* src/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg
// Operation codes and the control word carried along the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpc_pkg;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic valid;
    logic query;
    logic ok;
  } ctl_t;

endpackage

/* src/rpc_if.sv */
// ----------------------------------------------------------------------------
// rpc_if
// Request and response channels of rect_point_count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpc_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic        [1:0]            func;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] top;
  logic signed [COORD_BITS-1:0] bottom;
  logic signed [COORD_BITS-1:0] left;
  logic signed [COORD_BITS-1:0] right;

  modport source (
    output valid, func, point_x, point_y, top, bottom, left, right,
    input  ready
  );
  modport sink (
    input  valid, func, point_x, point_y, top, bottom, left, right,
    output ready
  );
endinterface

interface rpc_out_if #(
  parameter int CNT_BITS = 11
);
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] hit_count;
  logic                accepted;

  modport source (
    output valid, hit_count, accepted,
    input  ready
  );
  modport sink (
    input  valid, hit_count, accepted,
    output ready
  );
endinterface

/* src/rpc_cell.sv */
// ----------------------------------------------------------------------------
// rpc_cell
// One point slot of the chain: holds a point, tests each passing query
// against it and hands the word on to the next slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpc_cell #(
  parameter int COORD_BITS = 16,
  parameter int CNT_BITS   = 11,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         wr,
  input  logic        [CNT_BITS-1:0]   wr_idx,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  rpc_pkg::ctl_t                ctl_in,
  input  logic signed [COORD_BITS-1:0] lo_y_in,
  input  logic signed [COORD_BITS-1:0] hi_y_in,
  input  logic signed [COORD_BITS-1:0] lo_x_in,
  input  logic signed [COORD_BITS-1:0] hi_x_in,
  input  logic        [CNT_BITS-1:0]   tot_in,
  input  logic        [CNT_BITS-1:0]   cnt_in,
  output rpc_pkg::ctl_t                ctl,
  output logic signed [COORD_BITS-1:0] lo_y,
  output logic signed [COORD_BITS-1:0] hi_y,
  output logic signed [COORD_BITS-1:0] lo_x,
  output logic signed [COORD_BITS-1:0] hi_x,
  output logic        [CNT_BITS-1:0]   tot,
  output logic        [CNT_BITS-1:0]   cnt
);

  localparam logic [CNT_BITS-1:0] MyIdx = CNT_BITS'(INDEX);

  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic                         hit;

  // slot counts only for queries that saw it filled
  assign hit = ctl_in.valid && ctl_in.query && (MyIdx < tot_in) &&
               (py >= lo_y_in) && (py < hi_y_in) &&
               (px >= lo_x_in) && (px < hi_x_in);

  always_ff @(posedge clk) begin
    if (wr && (wr_idx == MyIdx)) begin
      px <= wr_x;
      py <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_y <= lo_y_in;
      hi_y <= hi_y_in;
      lo_x <= lo_x_in;
      hi_x <= hi_x_in;
      tot  <= tot_in;
      cnt  <= cnt_in + CNT_BITS'(hit);
    end
  end

endmodule

/* src/rect_point_count.sv */
// ----------------------------------------------------------------------------
// rect_point_count
// 2D point set with orthogonal half-open range counting, built as a chain
// of point cells that every word walks through.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | func, point_x, point_y, top, bottom, left, right
//  rsp     | out | hit_count, accepted
//
//  Every word enters the chain at once (one per cycle while not stalled);
//  responses leave in order, through CAPACITY cells and the rsp register.
//  Add writes its cell at acceptance; a query carries the fill count seen
//  at acceptance and counts only cells below it.
//  Reset empties the set and flushes the chain; point storage is not cleared.
//  A held response stalls the whole chain and req.ready together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rect_point_count #(
  parameter int CAPACITY   = 1024,
  parameter int COORD_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  rpc_in_if.sink   req,
  rpc_out_if.source rsp
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam logic [CNT_BITS-1:0] Cap = CNT_BITS'(CAPACITY);

  logic                adv;
  logic                take;
  logic [CNT_BITS-1:0] total;
  logic [CNT_BITS-1:0] total_next;
  logic                wr;
  logic                ok;

  rpc_pkg::ctl_t                chain_ctl  [CAPACITY+1];
  logic signed [COORD_BITS-1:0] chain_lo_y [CAPACITY+1];
  logic signed [COORD_BITS-1:0] chain_hi_y [CAPACITY+1];
  logic signed [COORD_BITS-1:0] chain_lo_x [CAPACITY+1];
  logic signed [COORD_BITS-1:0] chain_hi_x [CAPACITY+1];
  logic        [CNT_BITS-1:0]   chain_tot  [CAPACITY+1];
  logic        [CNT_BITS-1:0]   chain_cnt  [CAPACITY+1];

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;
  assign take      = req.valid && adv;

  always_comb begin
    total_next = total;
    wr         = 1'b0;
    ok         = 1'b0;
    unique case (req.func)
      rpc_pkg::FUNC_CLEAR: begin
        total_next = '0;
        ok         = 1'b1;
      end
      rpc_pkg::FUNC_ADD: begin
        if (total < Cap) begin
          total_next = total + 1'b1;
          wr         = 1'b1;
          ok         = 1'b1;
        end
      end
      rpc_pkg::FUNC_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (take) begin
      total <= total_next;
    end
  end

  assign chain_ctl[0].valid = take;
  assign chain_ctl[0].query = (req.func == rpc_pkg::FUNC_QUERY);
  assign chain_ctl[0].ok    = ok;
  assign chain_lo_y[0]      = req.top;
  assign chain_hi_y[0]      = req.bottom;
  assign chain_lo_x[0]      = req.left;
  assign chain_hi_x[0]      = req.right;
  assign chain_tot[0]       = total;
  assign chain_cnt[0]       = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rpc_cell #(
      .COORD_BITS (COORD_BITS),
      .CNT_BITS   (CNT_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .wr      (take && wr),
      .wr_idx  (total),
      .wr_x    (req.point_x),
      .wr_y    (req.point_y),
      .ctl_in  (chain_ctl[i]),
      .lo_y_in (chain_lo_y[i]),
      .hi_y_in (chain_hi_y[i]),
      .lo_x_in (chain_lo_x[i]),
      .hi_x_in (chain_hi_x[i]),
      .tot_in  (chain_tot[i]),
      .cnt_in  (chain_cnt[i]),
      .ctl     (chain_ctl[i+1]),
      .lo_y    (chain_lo_y[i+1]),
      .hi_y    (chain_hi_y[i+1]),
      .lo_x    (chain_lo_x[i+1]),
      .hi_x    (chain_hi_x[i+1]),
      .tot     (chain_tot[i+1]),
      .cnt     (chain_cnt[i+1])
    );
  end

  // response register at the chain tail
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= chain_ctl[CAPACITY].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.hit_count <= chain_cnt[CAPACITY];
      rsp.accepted  <= chain_ctl[CAPACITY].ok;
    end
  end

endmodule

/* src/rpc_checker.sv */
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks for rect_point_count, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rect_point_count_assert.svh"

module rpc_checker #(
  parameter int CNT_BITS = 11
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [CNT_BITS-1:0] rsp_hit_count,
  input logic                rsp_accepted
);

  `RPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit_count) && $stable(rsp_accepted))
  `RPC_ASSERT_NOW(a_stall_in, rsp_valid && !rsp_ready, !req_ready)
  `RPC_ASSERT_NOW(a_free_in, !rsp_valid, req_ready)
  `RPC_ASSERT_NOW(a_reject_zero, rsp_valid && !rsp_accepted, rsp_hit_count == '0)

endmodule

bind rect_point_count rpc_checker #(
  .CNT_BITS (CNT_BITS)
) u_rpc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_hit_count (rsp.hit_count),
  .rsp_accepted  (rsp.accepted)
);
